// ===== rtl/bol_pkg.sv =====
// shared types and codes for the bounded ordered list
// no dependencies; imported by the cell, the top level and the checker
`default_nettype none

package bol_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT     = 3'd4;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // per-cell update strobes
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bol_cell.sv =====
// one storage cell of the list: holds a single entry
// loads an appended value or takes its neighbour's entry on a removal; uses bol_pkg
`default_nettype none

module bol_cell
    import bol_pkg::*;
(
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] load_value,
    input  wire logic [DATA_W-1:0] next_value,
    output logic      [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift) begin
            data_next = next_value;
        end else if (ctrl.load) begin
            data_next = load_value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/bounded_ordered_list.sv =====
// top level of the bounded ordered list: a row of bol_cell entries and the control
// depends on bol_pkg and bol_cell
//
// usage
//   input channel s_*: one transaction is one operation (append, remove head,
//   remove tail, remove at index, read at index) with its value and index.
//   result channel m_*: one transaction per operation with status, read_value
//   and the entry count after the operation.
// result timing and throughput
//   the result is registered and shown in the cycle after acceptance. all cells
//   update together (a removal moves every later entry one cell toward the head
//   in parallel), so one operation is accepted per cycle unless stalled. the
//   figure is set by the single output register: a new operation is taken
//   whenever that register is empty or being read in the same cycle.
// stalls
//   while m_valid is high and m_ready low, the result holds and s_ready is
//   low; no operation is lost or taken twice.
// reset
//   aresetn (synchronous, active low) empties the list and the output
//   register. entry contents are not cleared; only entries below the count
//   are ever read, and those were all written by appends. no clearing pass.
`default_nettype none

module bounded_ordered_list
    import bol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [OP_W-1:0]    s_operation,
    input  wire logic signed [DATA_W-1:0]  s_value,
    input  wire logic        [INDEX_W-1:0] s_index,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic             [1:0]         m_status,
    output logic signed      [DATA_W-1:0]  m_read_value,
    output logic             [COUNT_W-1:0] m_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int RD_N = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);
    localparam int RIW  = $clog2(RD_N);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               m_valid_reg;
    status_t            m_status_reg;
    status_t            status_next;
    logic [DATA_W-1:0]  m_read_value_reg;
    logic [DATA_W-1:0]  read_next;
    logic [COUNT_W-1:0] m_count_reg;

    logic               accept;
    logic               list_empty;
    logic               list_full;
    logic               index_oob;
    logic               do_append;
    logic               do_shift;
    logic [CMPW-1:0]    shift_pos;
    logic [RIW-1:0]     rd_sel;

    logic [DATA_W-1:0]  cell_data [DEPTH];
    logic [DATA_W-1:0]  rd_taps   [RD_N];
    cell_ctrl_t         cell_ctrl [DEPTH];

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(DEPTH));
    // count never exceeds DEPTH, so this also covers an index beyond the row
    assign index_oob  = (CMPW'(s_index) >= CMPW'(count_reg));
    assign rd_sel     = s_index[RIW-1:0];

    always_comb begin
        status_next = ST_DONE;
        read_next   = '0;
        count_next  = count_reg;
        do_append   = 1'b0;
        do_shift    = 1'b0;
        shift_pos   = '0;
        case (s_operation)
            OP_APPEND: begin
                if (list_full) begin
                    status_next = ST_FULL;
                end else begin
                    do_append  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE_HEAD: begin
                if (list_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    do_shift   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REMOVE_TAIL: begin
                if (list_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (list_empty) begin
                    status_next = ST_EMPTY;
                end else if (index_oob) begin
                    status_next = ST_OOB;
                end else begin
                    do_shift   = 1'b1;
                    shift_pos  = CMPW'(s_index);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ_AT: begin
                if (index_oob) begin
                    status_next = ST_OOB;
                end else begin
                    read_next = rd_taps[rd_sel];
                end
            end
            default: begin
            end
        endcase
    end

    // the row of cells; cells at or past the removal point take their neighbour
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign cell_ctrl[k].load  = accept && do_append && (count_reg == CW'(k));
        assign cell_ctrl[k].shift = accept && do_shift && (CMPW'(k) >= shift_pos);

        bol_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[k]),
            .load_value (s_value),
            .next_value (cell_data[(k + 1 < DEPTH) ? k + 1 : k]),
            .data       (cell_data[k])
        );
    end

    // only the cells an index can reach feed the read select
    for (genvar r = 0; r < RD_N; r++) begin : g_tap
        assign rd_taps[r] = cell_data[r];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg     <= status_next;
            m_read_value_reg <= read_next;
            m_count_reg      <= COUNT_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;
    assign m_count      = m_count_reg;

endmodule

`default_nettype wire

// ===== rtl/bol_checker.sv =====
// port-level checks for bounded_ordered_list and the bind that attaches them
// depends on bol_pkg and the top level's port list
`default_nettype none

module bol_checker
    import bol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic        [1:0]         m_status,
    input wire logic signed [DATA_W-1:0]  m_read_value,
    input wire logic        [COUNT_W-1:0] m_count
);

    // a pending result holds until taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_count)
                                   && $stable(m_read_value)))
        else $error("result changed while stalled");

    // every accepted operation shows a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted operation gave no result");

    // a refused append only happens on a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_count == COUNT_W'(DEPTH)))
        else $error("full status with a count below depth");

    // empty status leaves an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_count == '0))
        else $error("empty status with entries held");

    // read data only comes with a successful operation
    a_read_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_value != 0) |-> (m_status == ST_DONE))
        else $error("read value on a failed operation");

endmodule

bind bounded_ordered_list bol_checker #(.DEPTH(DEPTH)) u_bol_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value),
    .m_count      (m_count)
);

`default_nettype wire
